// File: rtl/hsv_pkg.sv
// Shared types and constants for the HSV to RGB converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package hsv_pkg;

   // Pipeline depth, counting the output register
   localparam int NUM_STAGES = 7;

   // Hue wrap: hue + 6 turns, then mod 5760 = (upper bits mod 90) : low 6 bits
   localparam logic [16:0] HUE_OFFSET  = 17'd34560;
   localparam logic [6:0]  DEG_STEPS   = 7'd90;
   localparam logic [9:0]  DEG_RECIP   = 10'((1 << 16) / 90);
   localparam logic [9:0]  SECTOR_SPAN = 10'd960;

   // Component numerator full scale is 255*255*960, byte = N / (255*960)
   localparam logic [17:0] FULL_DIV  = 18'd244800;
   localparam logic [11:0] OUT_DIV   = 12'd3825;
   localparam logic [20:0] OUT_RECIP = 21'((64'd1 << 32) / 64'd3825);

   typedef struct packed {
      logic signed [15:0] hue;
      logic [7:0]         saturation;
      logic [7:0]         brightness_value;
   } hsv_req_type;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [23:0] packed_color;
   } hsv_rsp_type;

endpackage

`default_nettype wire

// File: rtl/hsv_to_rgb_converter_unit.sv
// HSV to RGB converter. Takes hue (1/16 degree, signed, wrapped modulo 360 deg),
// saturation and value (255 = 1.0) and returns truncated 8-bit red, green, blue
// and the packed 24-bit color. Fully pipelined: one beat per clock while the
// response is not stalled, through seven register stages (hue wrap, remainder,
// sector split, chroma products, numerators, reciprocal estimate, byte
// correction). A stalled response holds only the full stages with no empty stage
// ahead of them; the other stages keep moving. Stateless, no configuration.
// Depends on hsv_pkg, hsv_hue_split, hsv_comp_mix and hsv_byte_div.
`default_nettype none

module hsv_to_rgb_converter_unit
   import hsv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  hsv_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output hsv_rsp_type rsp_data
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] load;
   logic [2:0]  sector;
   logic [9:0]  frac;
   logic [25:0] red_num, green_num, blue_num;
   logic [7:0]  red, green, blue;

   // a stage loads when it is empty or the stage after it moves
   always_comb begin
      load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (load[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (load[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign req_stall = !load[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   hsv_hue_split u_split (
      .clock    (clock),
      .stage_en (load[2:0]),
      .hue      (req_data.hue),
      .sector   (sector),
      .frac     (frac)
   );

   hsv_comp_mix u_mix (
      .clock            (clock),
      .stage_en         (load[4:0]),
      .saturation       (req_data.saturation),
      .brightness_value (req_data.brightness_value),
      .sector           (sector),
      .frac             (frac),
      .red_num          (red_num),
      .green_num        (green_num),
      .blue_num         (blue_num)
   );

   hsv_byte_div u_div_red (
      .clock    (clock),
      .stage_en (load[6:5]),
      .num      (red_num),
      .byte_out (red)
   );

   hsv_byte_div u_div_green (
      .clock    (clock),
      .stage_en (load[6:5]),
      .num      (green_num),
      .byte_out (green)
   );

   hsv_byte_div u_div_blue (
      .clock    (clock),
      .stage_en (load[6:5]),
      .num      (blue_num),
      .byte_out (blue)
   );

   assign rsp_data.red          = red;
   assign rsp_data.green        = green;
   assign rsp_data.blue         = blue;
   assign rsp_data.packed_color = {red, green, blue};

endmodule

`default_nettype wire

// File: rtl/hsv_hue_split.sv
// Hue wrap and sector split: three register stages from raw hue to sector and fraction.
// Depends on hsv_pkg.
`default_nettype none

module hsv_hue_split
   import hsv_pkg::*;
(
   input  logic               clock,
   input  logic [2:0]         stage_en,
   input  logic signed [15:0] hue,
   output logic [2:0]         sector,
   output logic [9:0]         frac
);

   logic [16:0] hue_pos;
   logic [21:0] quot_prod;
   logic [10:0] deg_in,  deg_ff;
   logic [5:0]  lo1_ff,  lo2_ff;
   logic [3:0]  quot_in, quot_ff;
   logic [7:0]  rem_in,  rem_ff;
   logic [6:0]  deg_mod;
   logic [12:0] hue_wrap;
   logic [2:0]  sector_in, sector_ff;
   logic [12:0] base;
   logic [9:0]  frac_in, frac_ff;

   // stage 1: coarse quotient of (hue_pos>>6)/90, may be one low
   assign hue_pos   = {hue[15], hue} + HUE_OFFSET;
   assign deg_in    = hue_pos[16:6];
   assign quot_prod = 22'(deg_in) * 22'(DEG_RECIP);
   assign quot_in   = quot_prod[19:16];

   // stage 2: remainder, below 180
   assign rem_in = 8'(deg_ff - 11'(quot_ff) * 11'(DEG_STEPS));

   // stage 3: fix remainder, pick sector
   always_comb begin
      deg_mod  = (rem_ff >= 8'(DEG_STEPS)) ? 7'(rem_ff - 8'(DEG_STEPS)) : rem_ff[6:0];
      hue_wrap = {deg_mod, lo2_ff};
      if (hue_wrap >= 13'(5 * SECTOR_SPAN)) begin
         sector_in = 3'd5;
      end else if (hue_wrap >= 13'(4 * SECTOR_SPAN)) begin
         sector_in = 3'd4;
      end else if (hue_wrap >= 13'(3 * SECTOR_SPAN)) begin
         sector_in = 3'd3;
      end else if (hue_wrap >= 13'(2 * SECTOR_SPAN)) begin
         sector_in = 3'd2;
      end else if (hue_wrap >= 13'(SECTOR_SPAN)) begin
         sector_in = 3'd1;
      end else begin
         sector_in = 3'd0;
      end
      base    = 13'(sector_in) * 13'(SECTOR_SPAN);
      frac_in = 10'(hue_wrap - base);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         deg_ff  <= deg_in;
         quot_ff <= quot_in;
         lo1_ff  <= hue_pos[5:0];
      end
      if (stage_en[1]) begin
         rem_ff <= rem_in;
         lo2_ff <= lo1_ff;
      end
      if (stage_en[2]) begin
         sector_ff <= sector_in;
         frac_ff   <= frac_in;
      end
   end

   assign sector = sector_ff;
   assign frac   = frac_ff;

endmodule

`default_nettype wire

// File: rtl/hsv_comp_mix.sv
// Chroma products and per-component numerators: five register stages.
// Depends on hsv_pkg; sector and fraction come from hsv_hue_split.
`default_nettype none

module hsv_comp_mix
   import hsv_pkg::*;
(
   input  logic        clock,
   input  logic [4:0]  stage_en,
   input  logic [7:0]  saturation,
   input  logic [7:0]  brightness_value,
   input  logic [2:0]  sector,
   input  logic [9:0]  frac,
   output logic [25:0] red_num,
   output logic [25:0] green_num,
   output logic [25:0] blue_num
);

   // p = v*s, vb = v*255*960 (value at full scale)
   logic [15:0] p1_ff, p2_ff, p3_ff;
   logic [25:0] vb1_ff, vb2_ff, vb3_ff, vb4_ff;
   logic [25:0] px_ff, pnx_ff, pc_ff;
   logic [2:0]  sector4_ff;
   logic [25:0] red_in, green_in, blue_in;
   logic [25:0] red_ff, green_ff, blue_ff;
   logic [25:0] sub_r, sub_g, sub_b;

   // stage 5: component = vb minus the chroma part it does not get
   //   c -> 0, x -> p*(960-f), c-x -> p*f, zero -> p*960
   always_comb begin
      case (sector4_ff)
         3'd0: begin
            sub_r = '0;     sub_g = pnx_ff; sub_b = pc_ff;
         end
         3'd1: begin
            sub_r = px_ff;  sub_g = '0;     sub_b = pc_ff;
         end
         3'd2: begin
            sub_r = pc_ff;  sub_g = '0;     sub_b = pnx_ff;
         end
         3'd3: begin
            sub_r = pc_ff;  sub_g = px_ff;  sub_b = '0;
         end
         3'd4: begin
            sub_r = pnx_ff; sub_g = pc_ff;  sub_b = '0;
         end
         default: begin
            sub_r = '0;     sub_g = pc_ff;  sub_b = px_ff;
         end
      endcase
      red_in   = vb4_ff - sub_r;
      green_in = vb4_ff - sub_g;
      blue_in  = vb4_ff - sub_b;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         p1_ff  <= 16'(saturation) * 16'(brightness_value);
         vb1_ff <= 26'(brightness_value) * 26'(FULL_DIV);
      end
      if (stage_en[1]) begin
         p2_ff  <= p1_ff;
         vb2_ff <= vb1_ff;
      end
      if (stage_en[2]) begin
         p3_ff  <= p2_ff;
         vb3_ff <= vb2_ff;
      end
      if (stage_en[3]) begin
         px_ff      <= 26'(p3_ff) * 26'(frac);
         pnx_ff     <= 26'(p3_ff) * 26'(SECTOR_SPAN - frac);
         pc_ff      <= 26'(p3_ff) * 26'(SECTOR_SPAN);
         vb4_ff     <= vb3_ff;
         sector4_ff <= sector;
      end
      if (stage_en[4]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign red_num   = red_ff;
   assign green_num = green_ff;
   assign blue_num  = blue_ff;

endmodule

`default_nettype wire

// File: rtl/hsv_byte_div.sv
// Numerator to byte: floor(num / 244800) by reciprocal multiply and one correction.
// Two register stages, the second is the output byte. Depends on hsv_pkg.
`default_nettype none

module hsv_byte_div
   import hsv_pkg::*;
(
   input  logic        clock,
   input  logic [1:0]  stage_en,
   input  logic [25:0] num,
   output logic [7:0]  byte_out
);

   logic [19:0] n_in, n_ff;
   logic [40:0] prod;
   logic [7:0]  q_in, q_ff;
   logic [19:0] rem;
   logic [7:0]  byte_in, byte_ff;

   // low 6 bits of 244800 = 64*3825 drop out by shifting
   assign n_in = num[25:6];
   assign prod = 41'(n_in) * 41'(OUT_RECIP);
   assign q_in = prod[39:32];

   // estimate is exact or one low
   assign rem     = n_ff - 20'(q_ff) * 20'(OUT_DIV);
   assign byte_in = (rem >= 20'(OUT_DIV)) ? q_ff + 8'd1 : q_ff;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         n_ff <= n_in;
         q_ff <= q_in;
      end
      if (stage_en[1]) begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out = byte_ff;

endmodule

`default_nettype wire

// File: tb/sv/hsv_rgb_ledger_pkg.sv
// Scoreboard for the HSV to RGB converter: bit-exact color predictor plus a
// queue of colors still owed by the pipeline. Depends on hsv_pkg for the beat types.
package hsv_rgb_ledger_pkg;
   import hsv_pkg::*;

   localparam int unsigned WHEEL_STEPS  = 5760;           // 360 deg in 1/16 deg
   localparam int unsigned SECTOR_STEPS = 960;            // 60 deg
   localparam int unsigned FULL_SCALE   = 255 * 255 * 960;
   localparam int unsigned BYTE_SCALE   = 255 * 960;
   localparam int unsigned PRINT_CAP    = 50;

   typedef enum int unsigned {
      RED_TO_YELLOW,
      YELLOW_TO_GREEN,
      GREEN_TO_CYAN,
      CYAN_TO_BLUE,
      BLUE_TO_MAGENTA,
      MAGENTA_TO_RED
   } hue_sector_type;

   typedef struct {
      hsv_req_type src;
      hsv_rsp_type rgb;
   } color_expect_type;

   class rgb_ledger;
      color_expect_type pending_rgb[$];
      int unsigned      faults = 0;

      static function logic [7:0] scale_to_byte(int unsigned num);
         if (num > FULL_SCALE)
            num = FULL_SCALE;
         return 8'(num / BYTE_SCALE);
      endfunction

      // Numerators share the denominator 255*255*960, so everything is exact.
      static function hsv_rsp_type predict_rgb(hsv_req_type hsv);
         int             hue_in;
         int unsigned    wrapped, frac, sat_val, chroma, ramp, fall, offset;
         int unsigned    r_num, g_num, b_num;
         hue_sector_type sector;
         hsv_rsp_type    rgb;
         hue_in  = hsv.hue;
         wrapped = int'(hue_in + int'(6 * WHEEL_STEPS)) % WHEEL_STEPS;
         sector  = hue_sector_type'(wrapped / SECTOR_STEPS);
         frac    = wrapped % SECTOR_STEPS;
         sat_val = int'(hsv.saturation) * int'(hsv.brightness_value);
         chroma  = sat_val * SECTOR_STEPS;
         ramp    = sat_val * frac;
         fall    = chroma - ramp;
         offset  = int'(hsv.brightness_value) * 255 * SECTOR_STEPS - chroma;
         r_num   = 0;
         g_num   = 0;
         b_num   = 0;
         case (sector)
            RED_TO_YELLOW: begin
               r_num = chroma;
               g_num = ramp;
            end
            YELLOW_TO_GREEN: begin
               r_num = fall;
               g_num = chroma;
            end
            GREEN_TO_CYAN: begin
               g_num = chroma;
               b_num = ramp;
            end
            CYAN_TO_BLUE: begin
               g_num = fall;
               b_num = chroma;
            end
            BLUE_TO_MAGENTA: begin
               r_num = ramp;
               b_num = chroma;
            end
            default: begin
               r_num = chroma;
               b_num = fall;
            end
         endcase
         rgb.red          = scale_to_byte(r_num + offset);
         rgb.green        = scale_to_byte(g_num + offset);
         rgb.blue         = scale_to_byte(b_num + offset);
         rgb.packed_color = {rgb.red, rgb.green, rgb.blue};
         return rgb;
      endfunction

      function void note_hsv(hsv_req_type hsv);
         color_expect_type entry;
         entry.src = hsv;
         entry.rgb = predict_rgb(hsv);
         pending_rgb.push_back(entry);
      endfunction

      function int unsigned outstanding();
         return pending_rgb.size();
      endfunction

      task report_fault(string what);
         faults++;
         if (faults <= PRINT_CAP)
            $display("MISMATCH %s", what);
      endtask

      task compare_field(string name, int unsigned got_val, int unsigned want_val,
                         hsv_req_type src);
         if (got_val != want_val)
            report_fault($sformatf("%s: got %0d, expected %0d (hue %0d sat %0d val %0d)",
                                   name, got_val, want_val, src.hue, src.saturation,
                                   src.brightness_value));
      endtask

      task check_rgb(hsv_rsp_type got);
         color_expect_type want;
         if (pending_rgb.size() == 0) begin
            report_fault($sformatf("color beat %h with no request outstanding", got));
            return;
         end
         want = pending_rgb.pop_front();
         compare_field("red", got.red, want.rgb.red, want.src);
         compare_field("green", got.green, want.rgb.green, want.src);
         compare_field("blue", got.blue, want.rgb.blue, want.src);
         compare_field("packed_color", got.packed_color, want.rgb.packed_color, want.src);
      endtask
   endclass

endpackage

// File: tb/sv/tb_top.sv
// Top of the HSV to RGB converter testbench: clock, reset, request driver,
// random response stall, monitor and watchdog. Depends on hsv_pkg and hsv_rgb_ledger_pkg.
module tb_top;
   import hsv_pkg::*;
   import hsv_rgb_ledger_pkg::*;

   localparam int unsigned IDLE_LIMIT = 2000;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   hsv_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   hsv_rsp_type rsp_data;

   bit          calm        = 1'b0;
   int unsigned stall_hold  = 0;
   int unsigned idle_cycles = 0;
   int unsigned cycle_count = 0;
   rgb_ledger   ledger      = new();

   hsv_to_rgb_converter_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // calm stretches: no gaps and no stalls on either side
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 256 == 255)
         calm <= ($urandom_range(0, 3) == 0);
   end

   always @(posedge clock) begin
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else if (roll < 65) begin
         rsp_stall  <= 1'b0;
         stall_hold <= $urandom_range(0, 4);
      end else if (roll < 93) begin
         rsp_stall  <= 1'b1;
         stall_hold <= $urandom_range(0, 2);
      end else begin
         rsp_stall  <= 1'b1;
         stall_hold <= $urandom_range(10, 30);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            ledger.note_hsv(req_data);
         if (rsp_valid && !rsp_stall)
            ledger.check_rgb(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles == IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // mostly full range, some inside one turn, some right on sector edges
   function automatic logic signed [15:0] random_hue();
      int turn_edge;
      case ($urandom_range(0, 3))
         0, 1: return 16'($urandom_range(0, 65535));
         2: return 16'($urandom_range(0, WHEEL_STEPS - 1));
         default: begin
            turn_edge = int'($urandom_range(0, 68)) - 34;
            return 16'(turn_edge * int'(SECTOR_STEPS) + int'($urandom_range(0, 2)) - 1);
         end
      endcase
   endfunction

   function automatic logic [7:0] random_level();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 10)
         return 8'd0;
      if (roll < 20)
         return 8'd255;
      return 8'($urandom_range(0, 255));
   endfunction

   // valid is only dropped when a gap is wanted, so back-to-back beats keep it high
   task automatic send_hsv(logic signed [15:0] hue, logic [7:0] sat, logic [7:0] val);
      hsv_req_type hsv;
      int unsigned gap;
      hsv.hue              = hue;
      hsv.saturation       = sat;
      hsv.brightness_value = val;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= hsv;
      do @(posedge clock); while (req_stall);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_hsv(0, 255, 255);
      send_hsv(-32768, 255, 255);
      send_hsv(32767, 255, 255);
      send_hsv(-1, 255, 255);
      send_hsv(-16, 255, 255);          // minus one degree wraps to 359
      send_hsv(5759, 128, 200);
      send_hsv(5760, 255, 255);
      send_hsv(-5760, 255, 255);
      send_hsv(959, 255, 255);
      send_hsv(960, 255, 255);          // sector boundaries, fraction zero
      send_hsv(1920, 255, 255);
      send_hsv(2880, 255, 255);
      send_hsv(3840, 255, 255);
      send_hsv(4800, 255, 255);
      send_hsv(4799, 255, 255);
      send_hsv(1000, 0, 255);           // gray
      send_hsv(3000, 255, 0);           // black
      send_hsv(2000, 0, 0);
      send_hsv(-5000, 1, 1);
      send_hsv(2500, 255, 1);
      for (int sec = 0; sec < 6; sec++)
         send_hsv(16'(sec * int'(SECTOR_STEPS) + 480), 200, 180);

      repeat (400)
         send_hsv(random_hue(), random_level(), random_level());
      req_valid <= 1'b0;
      @(posedge clock);

      while (ledger.outstanding() != 0)
         @(posedge clock);
      repeat (4 * NUM_STAGES) @(posedge clock);

      if (ledger.faults == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// File: hsv_to_rgb_converter_unit.f
rtl/hsv_pkg.sv
rtl/hsv_hue_split.sv
rtl/hsv_comp_mix.sv
rtl/hsv_byte_div.sv
rtl/hsv_to_rgb_converter_unit.sv
tb/sv/hsv_rgb_ledger_pkg.sv
tb/sv/tb_top.sv
